// ----- rtl/core/buddy_block_allocator_core_macros.svh -----
// Assertion helpers shared by the core
`ifndef BUDDY_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define BBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/bba_pkg.sv -----
package bba_pkg;

    localparam int MAX_ORDER = 10;
    localparam int AW        = MAX_ORDER;      // unit address width
    localparam int LW        = AW + 1;         // link width, NIL is 2^AW
    localparam int OW        = 4;              // order width
    localparam int POOL      = 1 << AW;
    localparam logic [LW-1:0] NIL = LW'(POOL);

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    typedef struct packed {
        logic [LW-1:0] nxt;
        logic [LW-1:0] prv;
    } link_t;

    typedef struct packed {
        logic          inl;
        logic [OW-1:0] ord;
    } meta_t;

    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_CLR    = 16'h0002,
        S_SCAN   = 16'h0004,
        S_ASPLIT = 16'h0008,
        S_AFIN   = 16'h0010,
        S_FRD    = 16'h0020,
        S_FCHK   = 16'h0040,
        S_M0     = 16'h0080,
        S_M1     = 16'h0100,
        S_UL0    = 16'h0200,
        S_UL1    = 16'h0400,
        S_UL2    = 16'h0800,
        S_UL3    = 16'h1000,
        S_UL4    = 16'h2000,
        S_P0     = 16'h4000,
        S_P1     = 16'h8000
    } state_t;

endpackage

// ----- rtl/core/bba_ram.sv -----
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/buddy_block_allocator_core.sv -----
// Buddy allocator over a pool of 2^total_order units (total_order <= 10).
// Request: pulse start while busy is low with mode (0 allocate, 1 free),
// req_order and block_addr; the request is taken at that edge and busy
// rises until the result is out; a request rejected at once gives done without busy.
// Result: done is high for exactly one cycle with status and result_addr;
// the receiver cannot stall, so it must take the result in that cycle.
// cfg_we/cfg_data writes total_order (saturates at 10) and reinitializes.
// The sequencer works around the link and meta RAMs (each with one write
// port and one registered read port) in these steps:
//   allocate: scan the orders, unlink the found block, then split it down to the requested order
//   free:     read and check the block, merge with each free buddy, then the final check and push
//   order out of range or bad free address: rejected from idle without busy
// One request at a time; the next may be taken at the edge ending the done cycle.
// After reset and after every config write a clearing pass sweeps the
// meta RAM; busy stays high meanwhile. Reset leaves the pool as one free
// block of order 10.
module buddy_block_allocator_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  mode,
    input  logic [3:0]            req_order,
    input  logic [9:0]            block_addr,
    input  logic                  cfg_we,
    input  logic [3:0]            cfg_data,
    output logic                  done,
    output logic [1:0]            status,
    output logic [9:0]            result_addr
);
    import bba_pkg::*;

    state_t          state_reg, state_next;
    logic            mode_reg, mode_next;
    logic [OW-1:0]   req_reg, req_next;
    logic [OW-1:0]   cur_reg, cur_next;
    logic [OW-1:0]   total_reg, total_next;
    logic [AW-1:0]   addr_reg, addr_next;
    logic [AW-1:0]   ul_reg, ul_next;
    logic [AW-1:0]   push_reg, push_next;
    logic [LW-1:0]   p_reg, p_next;
    logic [LW-1:0]   n_reg, n_next;
    logic [LW-1:0]   h_reg, h_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic [LW-1:0]   head_reg [MAX_ORDER+1];
    logic [LW-1:0]   head_next [MAX_ORDER+1];
    logic            done_reg, done_next;
    logic [1:0]      status_reg, status_next;
    logic [AW-1:0]   res_reg, res_next;

    logic            lk_we, mt_we;
    logic [AW-1:0]   lk_waddr, lk_raddr, mt_waddr, mt_raddr;
    link_t           lk_wdata, lk_rdata;
    meta_t           mt_wdata, mt_rdata;

    logic [OW-1:0]   cfg_sat;
    logic [AW+1:0]   free_end;
    logic [AW:0]     align_mask;
    logic            free_bad;

    assign cfg_sat    = (cfg_data > OW'(MAX_ORDER)) ? OW'(MAX_ORDER) : cfg_data;
    assign free_end   = (AW+2)'(block_addr) + ((AW+2)'(1) << req_order);
    assign align_mask = ((AW+1)'(1) << req_order) - (AW+1)'(1);
    assign free_bad   = (req_order > total_reg)
                     || (free_end > ((AW+2)'(1) << total_reg))
                     || (((AW+1)'(block_addr) & align_mask) != '0);

    bba_ram #(.WIDTH($bits(link_t)), .DEPTH(POOL)) u_links (
        .clk   (clk),
        .we    (lk_we),
        .waddr (lk_waddr),
        .wdata (lk_wdata),
        .raddr (lk_raddr),
        .rdata (lk_rdata)
    );

    bba_ram #(.WIDTH($bits(meta_t)), .DEPTH(POOL)) u_meta (
        .clk   (clk),
        .we    (mt_we),
        .waddr (mt_waddr),
        .wdata (mt_wdata),
        .raddr (mt_raddr),
        .rdata (mt_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        req_next    = req_reg;
        cur_next    = cur_reg;
        total_next  = total_reg;
        addr_next   = addr_reg;
        ul_next     = ul_reg;
        push_next   = push_reg;
        p_next      = p_reg;
        n_next      = n_reg;
        h_next      = h_reg;
        clr_next    = clr_reg;
        head_next   = head_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        res_next    = res_reg;
        lk_we       = 1'b0;
        lk_waddr    = '0;
        lk_wdata    = '0;
        lk_raddr    = '0;
        mt_we       = 1'b0;
        mt_waddr    = '0;
        mt_wdata    = '0;
        mt_raddr    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next = mode;
                    req_next  = req_order;
                    addr_next = block_addr;
                    cur_next  = req_order;
                    if (!mode)
                    begin
                        if (req_order > total_reg)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_NOSPACE;
                            res_next    = '0;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else if (free_bad)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_INVALID;
                        res_next    = '0;
                    end
                    else
                    begin
                        state_next = S_FRD;
                    end
                end
            end
            S_CLR:
            begin
                mt_we    = 1'b1;
                mt_waddr = clr_reg;
                if (clr_reg == '0)
                begin
                    // last entry: unit 0 holds the whole pool
                    mt_wdata   = '{inl: 1'b1, ord: total_reg};
                    lk_we      = 1'b1;
                    lk_waddr   = '0;
                    lk_wdata   = '{nxt: NIL, prv: NIL};
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg - AW'(1);
                end
            end
            S_SCAN:
            begin
                if (cur_reg > total_reg)
                begin
                    done_next   = 1'b1;
                    status_next = ST_NOSPACE;
                    res_next    = '0;
                    state_next  = S_IDLE;
                end
                else if (head_reg[cur_reg] != NIL)
                begin
                    addr_next  = head_reg[cur_reg][AW-1:0];
                    ul_next    = head_reg[cur_reg][AW-1:0];
                    state_next = S_UL0;
                end
                else
                begin
                    cur_next = cur_reg + OW'(1);
                end
            end
            S_ASPLIT:
            begin
                if (cur_reg > req_reg)
                begin
                    cur_next   = cur_reg - OW'(1);
                    push_next  = addr_reg + (AW'(1) << (cur_reg - OW'(1)));
                    state_next = S_P0;
                end
                else
                begin
                    state_next = S_AFIN;
                end
            end
            S_AFIN:
            begin
                mt_we       = 1'b1;
                mt_waddr    = addr_reg;
                mt_wdata    = '{inl: 1'b0, ord: req_reg};
                done_next   = 1'b1;
                status_next = ST_DONE;
                res_next    = addr_reg;
                state_next  = S_IDLE;
            end
            S_FRD:
            begin
                mt_raddr   = addr_reg;
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (mt_rdata.inl || (mt_rdata.ord != req_reg))
                begin
                    done_next   = 1'b1;
                    status_next = ST_INVALID;
                    res_next    = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_M0;
                end
            end
            S_M0:
            begin
                if (cur_reg < total_reg)
                begin
                    ul_next    = addr_reg ^ (AW'(1) << cur_reg);
                    mt_raddr   = addr_reg ^ (AW'(1) << cur_reg);
                    state_next = S_M1;
                end
                else
                begin
                    push_next  = addr_reg;
                    state_next = S_P0;
                end
            end
            S_M1:
            begin
                if (!mt_rdata.inl || (mt_rdata.ord != cur_reg))
                begin
                    push_next  = addr_reg;
                    state_next = S_P0;
                end
                else
                begin
                    state_next = S_UL0;
                end
            end
            S_UL0:
            begin
                lk_raddr   = ul_reg;
                state_next = S_UL1;
            end
            S_UL1:
            begin
                p_next   = lk_rdata.prv;
                n_next   = lk_rdata.nxt;
                mt_we    = 1'b1;
                mt_waddr = ul_reg;
                mt_wdata = '{inl: 1'b0, ord: cur_reg};
                if (lk_rdata.prv != NIL)
                begin
                    lk_raddr   = lk_rdata.prv[AW-1:0];
                    state_next = S_UL2;
                end
                else
                begin
                    head_next[cur_reg] = lk_rdata.nxt;
                    state_next         = S_UL3;
                end
            end
            S_UL2:
            begin
                lk_we      = 1'b1;
                lk_waddr   = p_reg[AW-1:0];
                lk_wdata   = '{nxt: n_reg, prv: lk_rdata.prv};
                state_next = S_UL3;
            end
            S_UL3, S_UL4:
            begin
                if (state_reg == S_UL3 && n_reg != NIL)
                begin
                    lk_raddr   = n_reg[AW-1:0];
                    state_next = S_UL4;
                end
                else
                begin
                    if (state_reg == S_UL4)
                    begin
                        lk_we    = 1'b1;
                        lk_waddr = n_reg[AW-1:0];
                        lk_wdata = '{nxt: lk_rdata.nxt, prv: p_reg};
                    end
                    if (!mode_reg)
                    begin
                        state_next = S_ASPLIT;
                    end
                    else
                    begin
                        // merged block starts at the lower buddy
                        addr_next  = addr_reg & ~(AW'(1) << cur_reg);
                        cur_next   = cur_reg + OW'(1);
                        state_next = S_M0;
                    end
                end
            end
            S_P0, S_P1:
            begin
                if (state_reg == S_P0)
                begin
                    h_next             = head_reg[cur_reg];
                    lk_we              = 1'b1;
                    lk_waddr           = push_reg;
                    lk_wdata           = '{nxt: head_reg[cur_reg], prv: NIL};
                    mt_we              = 1'b1;
                    mt_waddr           = push_reg;
                    mt_wdata           = '{inl: 1'b1, ord: cur_reg};
                    head_next[cur_reg] = {1'b0, push_reg};
                    lk_raddr           = head_reg[cur_reg][AW-1:0];
                end
                else
                begin
                    lk_we    = 1'b1;
                    lk_waddr = h_reg[AW-1:0];
                    lk_wdata = '{nxt: lk_rdata.nxt, prv: {1'b0, push_reg}};
                end
                if (state_reg == S_P0 && head_reg[cur_reg] != NIL)
                begin
                    state_next = S_P1;
                end
                else if (!mode_reg)
                begin
                    state_next = S_ASPLIT;
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = ST_DONE;
                    res_next    = addr_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // config write restarts the pool from any state
        if (cfg_we)
        begin
            total_next = cfg_sat;
            clr_next   = AW'(POOL - 1);
            state_next = S_CLR;
            done_next  = 1'b0;
            for (int i = 0; i <= MAX_ORDER; i++)
            begin
                head_next[i] = (OW'(i) == cfg_sat) ? '0 : NIL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            total_reg <= OW'(MAX_ORDER);
            clr_reg   <= AW'(POOL - 1);
            done_reg  <= 1'b0;
            for (int i = 0; i <= MAX_ORDER; i++)
            begin
                head_reg[i] <= (i == MAX_ORDER) ? '0 : NIL;
            end
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
            head_reg  <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        req_reg    <= req_next;
        cur_reg    <= cur_next;
        addr_reg   <= addr_next;
        ul_reg     <= ul_next;
        push_reg   <= push_next;
        p_reg      <= p_next;
        n_reg      <= n_next;
        h_reg      <= h_next;
        status_reg <= status_next;
        res_reg    <= res_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign result_addr = res_reg;

`include "buddy_block_allocator_core_macros.svh"

    `BBA_ASSERT_NEXT(a_busy_after_req, start && !busy && !cfg_we, busy || done, "request not taken")
    `BBA_ASSERT_NEXT(a_cfg_clears, cfg_we, busy && !done, "config did not start clearing")
    `BBA_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")
    `BBA_ASSERT_NOW(a_fail_zero, done && status != ST_DONE, result_addr == '0, "failed result has address")

endmodule
